>>> sv/trqt_pkg.sv
// ----------------------------------------------------------------------------
// trqt_pkg
// Shared constants and types for the quarter-turn tile rotator.
// ----------------------------------------------------------------------------
package trqt_pkg;

   localparam int TILE_SIDE   = 16;
   localparam int SIDE_W      = $clog2(TILE_SIDE);
   localparam int TILE_PIXELS = TILE_SIDE * TILE_SIDE;
   localparam int ADDR_W      = $clog2(TILE_PIXELS);
   localparam int CHAN_W      = 8;
   localparam int PIXEL_W     = 3 * CHAN_W;

   localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(TILE_SIDE - 1);
   localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(TILE_PIXELS - 1);

   // operation codes carried on tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // rotation select codes
   localparam logic ROT_90  = 1'b0;
   localparam logic ROT_270 = 1'b1;

   typedef struct packed {
      logic write;   // store the incoming pixel at the load position
      logic fetch;   // read the next rotated pixel into the output register
   } cmd_type;

endpackage

>>> sv/tile_rotate_quarter_turn_core.sv
// ----------------------------------------------------------------------------
// tile_rotate_quarter_turn_core
// Quarter-turn rotator for one square tile of RGB pixels.
//
//   channel   direction   contents
//   req       in          tuser: operation, tdata: red, green, blue
//   rsp       out         tdata: red, green, blue, tlast: tile end
//   csr       in          rotation select (write only)
//
// A load item writes one store entry.
// A read item performs one store read; its pixel is valid the cycle after it
// is accepted and is held until taken, while a further item may enter in the
// cycle that pixel leaves, so reads run at one per cycle with rsp_tready high.
// Reset clears both position counters and selects 270 degrees; the tile store
// is not cleared.
// ----------------------------------------------------------------------------
module tile_rotate_quarter_turn_core
   import trqt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic        rsp_tlast,   // tile_end
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   cmd_type cmd;

   trqt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   trqt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .pixel_in    (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pixel_out   (rsp_tdata),
      .tile_end    (rsp_tlast)
   );

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write && cmd.fetch))
      else $error("load and read issued together");

   a_read_gives_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_READ) |=> rsp_tvalid)
      else $error("accepted read item produced no pixel");

   a_load_no_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_LOAD && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("load item produced a pixel");

   a_fetch_matches_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch == (req_tvalid && req_tready && req_tuser == OP_READ))
      else $error("store read not tied to an accepted read item");

endmodule

>>> sv/trqt_ctrl.sv
// ----------------------------------------------------------------------------
// trqt_ctrl
// Handshake controller: accepts items and tracks the pending output pixel.
// ----------------------------------------------------------------------------
module trqt_ctrl
   import trqt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_tuser,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SEND = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // a new item may enter while the held pixel leaves in the same cycle
   assign req_tready = (state_ff == ST_IDLE) || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_SEND);

   assign cmd.write = accept && (req_tuser == OP_LOAD);
   assign cmd.fetch = accept && (req_tuser == OP_READ);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.fetch) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_tready && !cmd.fetch) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/trqt_datapath.sv
// ----------------------------------------------------------------------------
// trqt_datapath
// Tile store, load and read position counters, rotated address generation.
// ----------------------------------------------------------------------------
module trqt_datapath
   import trqt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [PIXEL_W-1:0] pixel_in,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   output logic [PIXEL_W-1:0] pixel_out,
   output logic               tile_end
);

   logic [PIXEL_W-1:0] store [TILE_PIXELS];

   logic [ADDR_W-1:0]  ld_pos_ff;
   logic [ADDR_W-1:0]  ld_pos_in;
   logic [SIDE_W-1:0]  rd_row_ff;
   logic [SIDE_W-1:0]  rd_row_in;
   logic [SIDE_W-1:0]  rd_col_ff;
   logic [SIDE_W-1:0]  rd_col_in;
   logic               rot_ff;
   logic               rot_in;
   logic [PIXEL_W-1:0] rd_data_ff;
   logic               last_ff;
   logic               last_in;
   logic [SIDE_W-1:0]  src_row;
   logic [SIDE_W-1:0]  src_col;
   logic [ADDR_W-1:0]  src_addr;

   // output (r,c) maps to input (N-1-c, r) for 90 and (c, N-1-r) for 270
   always_comb begin
      unique case (rot_ff)
         ROT_90: begin
            src_row = SIDE_MAX - rd_col_ff;
            src_col = rd_row_ff;
         end
         ROT_270: begin
            src_row = rd_col_ff;
            src_col = SIDE_MAX - rd_row_ff;
         end
         default: begin
            src_row = rd_col_ff;
            src_col = rd_row_ff;
         end
      endcase
      src_addr = ADDR_W'(ADDR_W'(src_row) * ADDR_W'(TILE_SIDE)) + ADDR_W'(src_col);
   end

   assign last_in = (rd_row_ff == SIDE_MAX) && (rd_col_ff == SIDE_MAX);

   always_comb begin
      ld_pos_in = ld_pos_ff;
      if (cmd.write) begin
         ld_pos_in = (ld_pos_ff == ADDR_MAX) ? '0 : ld_pos_ff + 1'b1;
      end
   end

   always_comb begin
      rd_row_in = rd_row_ff;
      rd_col_in = rd_col_ff;
      if (cmd.fetch) begin
         if (rd_col_ff == SIDE_MAX) begin
            rd_col_in = '0;
            rd_row_in = (rd_row_ff == SIDE_MAX) ? '0 : rd_row_ff + 1'b1;
         end else begin
            rd_col_in = rd_col_ff + 1'b1;
         end
      end
   end

   assign rot_in = csr_wr_en ? csr_wr_data : rot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_pos_ff <= '0;
         rd_row_ff <= '0;
         rd_col_ff <= '0;
         rot_ff    <= ROT_270;
      end else begin
         ld_pos_ff <= ld_pos_in;
         rd_row_ff <= rd_row_in;
         rd_col_ff <= rd_col_in;
         rot_ff    <= rot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         store[ld_pos_ff] <= pixel_in;
      end
   end

   // read data register doubles as the output holding register
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_data_ff <= store[src_addr];
         last_ff    <= last_in;
      end
   end

   assign pixel_out = rd_data_ff;
   assign tile_end  = last_ff;

endmodule
